>>> rtl/lge_pkg.sv
package lge_pkg;

	// configuration register width and indexes
	localparam int REG_W = 7;
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// smallest usable grid dimension
	localparam logic [REG_W-1:0] DIM_MIN = 7'd3;

	// Life rule thresholds
	localparam logic [3:0] BORN_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT = 4'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] row;
		logic [5:0] col;
		logic       cell_value;
	} in_item_t;

	typedef struct packed {
		logic cell_state;
		logic step_done;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_WAIT,
		ST_GEN_SCAN,
		ST_GEN_DRAIN,
		ST_COPY_SCAN,
		ST_COPY_DRAIN
	} lge_state_t;

endpackage

>>> rtl/lge_ram.sv
module lge_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/life_generation_engine_top.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------
// in       | in_valid / in_stall | in_data   (lge_pkg::in_item_t)
// out      | out_valid/ out_stall| out_data  (lge_pkg::out_item_t)
// cfg      | cfg_we              | cfg_index, cfg_data (0 rows, 1 columns)
//
// Write and unused commands set the result on acceptance; a read passes ST_READ_WAIT.
// Step: scans the cell RAM, nc+2 columns per row (one read port, a 3-column
//   window per row), then copies the scratch RAM back into the cell RAM.
// After reset a clearing pass writes every cell of the cell RAM dead;
//   in_stall is high meanwhile.
// in_stall is high while a transaction is in work or a result waits stalled.
module life_generation_engine_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  lge_pkg::in_item_t       in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output lge_pkg::out_item_t      out_data,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [lge_pkg::REG_W-1:0] cfg_data
);

	localparam int RW      = $clog2(MAX_ROWS);
	localparam int CW      = $clog2(MAX_COLS);
	localparam int AW      = RW + CW;
	localparam int DEPTH   = 1 << AW;
	localparam int KW      = $clog2(MAX_COLS + 2);
	localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;

	// configuration registers
	logic [lge_pkg::REG_W-1:0] rows_q, cols_q;
	logic [lge_pkg::REG_W-1:0] nr7, nc7;
	logic [RW-1:0]             nr_m1;
	logic [CW-1:0]             nc_m1;

	// control
	lge_pkg::lge_state_t state_q, state_d;
	logic [AW-1:0]       clr_addr_q;
	logic [RW-1:0]       r_q;
	logic [KW-1:0]       k_q;
	logic [1:0]          j_q;
	logic                accept, take, in_grid;
	logic [AW-1:0]       cmd_addr;
	logic                issue_gen, issue_copy;
	logic                gen_last, copy_last;
	logic [KW-1:0]       k_last;

	// scan address
	logic [RW-1:0] up_row, dn_row, scan_row;
	logic [CW-1:0] scan_col;

	// generation pipeline
	logic          gen_vld_s1;
	logic [1:0]    gen_j_s1;
	logic [KW-1:0] gen_k_s1;
	logic [RW-1:0] gen_r_s1;
	logic [1:0]    col_buf_q;
	logic [2:0]    win_a_q, win_b_q, new_col;
	logic          gen_col_done, gen_we, gen_next;
	logic [3:0]    nb_count;
	logic [AW-1:0] gen_waddr;

	// copy pipeline
	logic          copy_vld_s1;
	logic [AW-1:0] copy_addr_s1;

	// RAM ports
	logic          cur_we, cur_wdata, cur_rdata, nxt_rdata;
	logic [AW-1:0] cur_waddr, cur_raddr;

	// output register
	logic                out_valid_q;
	lge_pkg::out_item_t  out_data_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// clamp the in-use dimensions
	always_comb begin
		if (rows_q < lge_pkg::DIM_MIN) begin
			nr7 = lge_pkg::DIM_MIN;
		end else if (rows_q > 7'(ROW_CAP)) begin
			nr7 = 7'(ROW_CAP);
		end else begin
			nr7 = rows_q;
		end
		if (cols_q < lge_pkg::DIM_MIN) begin
			nc7 = lge_pkg::DIM_MIN;
		end else if (cols_q > 7'(COL_CAP)) begin
			nc7 = 7'(COL_CAP);
		end else begin
			nc7 = cols_q;
		end
	end

	assign nr_m1  = RW'(nr7 - 7'd1);
	assign nc_m1  = CW'(nc7 - 7'd1);
	assign k_last = KW'(nc_m1) + KW'(2);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_index == lge_pkg::CFG_ROWS) begin
				rows_q <= cfg_data;
			end else begin
				cols_q <= cfg_data;
			end
		end
	end

	// command decode
	assign take     = out_valid_q && !out_stall;
	assign in_stall = (state_q != lge_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign in_grid  = (int'(in_data.row) < MAX_ROWS) && (int'(in_data.col) < MAX_COLS);
	assign cmd_addr = {RW'(in_data.row), CW'(in_data.col)};

	// neighbour row for each of the three reads of a column
	always_comb begin
		up_row = (r_q == '0) ? nr_m1 : r_q - RW'(1);
		dn_row = (r_q == nr_m1) ? '0 : r_q + RW'(1);
		unique case (j_q)
			2'd0:    scan_row = up_row;
			2'd1:    scan_row = r_q;
			default: scan_row = dn_row;
		endcase
		if (k_q == '0) begin
			scan_col = nc_m1;
		end else if (k_q == k_last) begin
			scan_col = '0;
		end else begin
			scan_col = CW'(k_q - KW'(1));
		end
	end

	assign gen_last  = (j_q == 2'd2) && (k_q == k_last) && (r_q == nr_m1);
	assign copy_last = (k_q == KW'(nc_m1)) && (r_q == nr_m1);

	// next state
	always_comb begin
		state_d    = state_q;
		issue_gen  = 1'b0;
		issue_copy = 1'b0;
		unique case (state_q)
			lge_pkg::ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_d = lge_pkg::ST_IDLE;
				end
			end
			lge_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_data.command == lge_pkg::CMD_READ && in_grid) begin
						state_d = lge_pkg::ST_READ_WAIT;
					end else if (in_data.command == lge_pkg::CMD_STEP) begin
						state_d = lge_pkg::ST_GEN_SCAN;
					end
				end
			end
			lge_pkg::ST_READ_WAIT: begin
				state_d = lge_pkg::ST_IDLE;
			end
			lge_pkg::ST_GEN_SCAN: begin
				issue_gen = 1'b1;
				if (gen_last) begin
					state_d = lge_pkg::ST_GEN_DRAIN;
				end
			end
			lge_pkg::ST_GEN_DRAIN: begin
				state_d = lge_pkg::ST_COPY_SCAN;
			end
			lge_pkg::ST_COPY_SCAN: begin
				issue_copy = 1'b1;
				if (copy_last) begin
					state_d = lge_pkg::ST_COPY_DRAIN;
				end
			end
			lge_pkg::ST_COPY_DRAIN: begin
				state_d = lge_pkg::ST_IDLE;
			end
			default: begin
				state_d = lge_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lge_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clearing pass and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			r_q        <= '0;
			k_q        <= '0;
			j_q        <= '0;
		end else begin
			if (state_q == lge_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (accept) begin
				r_q <= '0;
				k_q <= '0;
				j_q <= '0;
			end else if (issue_gen) begin
				if (j_q == 2'd2) begin
					j_q <= '0;
					if (k_q == k_last) begin
						k_q <= '0;
						r_q <= (r_q == nr_m1) ? '0 : r_q + RW'(1);
					end else begin
						k_q <= k_q + KW'(1);
					end
				end else begin
					j_q <= j_q + 2'd1;
				end
			end else if (issue_copy) begin
				if (k_q == KW'(nc_m1)) begin
					k_q <= '0;
					r_q <= r_q + RW'(1);
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
		end
	end

	// read tags, registered alongside the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_vld_s1  <= 1'b0;
			copy_vld_s1 <= 1'b0;
		end else begin
			gen_vld_s1  <= issue_gen;
			copy_vld_s1 <= issue_copy;
		end
	end

	always_ff @(posedge clk) begin
		gen_j_s1     <= j_q;
		gen_k_s1     <= k_q;
		gen_r_s1     <= r_q;
		copy_addr_s1 <= {r_q, CW'(k_q)};
	end

	// column assembly and the 3x3 window
	assign gen_col_done = gen_vld_s1 && (gen_j_s1 == 2'd2);
	assign new_col      = {col_buf_q[0], col_buf_q[1], cur_rdata};

	always_ff @(posedge clk) begin
		if (gen_vld_s1 && gen_j_s1 == 2'd0) begin
			col_buf_q[0] <= cur_rdata;
		end
		if (gen_vld_s1 && gen_j_s1 == 2'd1) begin
			col_buf_q[1] <= cur_rdata;
		end
		if (gen_col_done) begin
			win_a_q <= win_b_q;
			win_b_q <= new_col;
		end
	end

	// neighbour count and Life rule for the cell in the middle column
	always_comb begin
		nb_count = 4'(win_a_q[2]) + 4'(win_a_q[1]) + 4'(win_a_q[0])
			+ 4'(win_b_q[2]) + 4'(win_b_q[0])
			+ 4'(new_col[2]) + 4'(new_col[1]) + 4'(new_col[0]);
		gen_next = (nb_count == lge_pkg::BORN_COUNT)
			|| (nb_count == lge_pkg::KEEP_COUNT && win_b_q[1]);
	end

	assign gen_we    = gen_col_done && (gen_k_s1 >= KW'(2));
	assign gen_waddr = {gen_r_s1, CW'(gen_k_s1 - KW'(2))};

	// cell RAM port selection
	always_comb begin
		cur_we    = 1'b0;
		cur_waddr = cmd_addr;
		cur_wdata = in_data.cell_value;
		if (state_q == lge_pkg::ST_CLEAR) begin
			cur_we    = 1'b1;
			cur_waddr = clr_addr_q;
			cur_wdata = 1'b0;
		end else if (copy_vld_s1) begin
			cur_we    = 1'b1;
			cur_waddr = copy_addr_s1;
			cur_wdata = nxt_rdata;
		end else if (accept && in_data.command == lge_pkg::CMD_WRITE && in_grid) begin
			cur_we = 1'b1;
		end
		cur_raddr = (state_q == lge_pkg::ST_GEN_SCAN) ? {scan_row, scan_col} : cmd_addr;
	end

	lge_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_cur_ram (
		.clk  (clk),
		.we   (cur_we),
		.waddr(cur_waddr),
		.wdata(cur_wdata),
		.raddr(cur_raddr),
		.rdata(cur_rdata)
	);

	lge_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_nxt_ram (
		.clk  (clk),
		.we   (gen_we),
		.waddr(gen_waddr),
		.wdata(gen_next),
		.raddr({r_q, CW'(k_q)}),
		.rdata(nxt_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !(in_data.command == lge_pkg::CMD_READ && in_grid)
				&& in_data.command != lge_pkg::CMD_STEP) begin
			out_valid_q <= 1'b1;
		end else if (state_q == lge_pkg::ST_READ_WAIT || state_q == lge_pkg::ST_COPY_DRAIN) begin
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.cell_state <= (in_data.command == lge_pkg::CMD_WRITE) && in_grid
				&& in_data.cell_value;
			out_data_q.step_done  <= 1'b0;
		end else if (state_q == lge_pkg::ST_READ_WAIT) begin
			out_data_q.cell_state <= cur_rdata;
			out_data_q.step_done  <= 1'b0;
		end else if (state_q == lge_pkg::ST_COPY_DRAIN) begin
			out_data_q.cell_state <= 1'b0;
			out_data_q.step_done  <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	// scan writes and copy writes belong to separate phases
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(gen_we && copy_vld_s1))
		else $error("generation write overlaps copy write");

	// generation writes stay inside the in-use rows
	a_gen_row: assert property (@(posedge clk) disable iff (!arst_n)
		gen_we |-> (gen_r_s1 <= nr_m1))
		else $error("generation write outside in-use rows");

	// end of the copy phase presents a step result
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lge_pkg::ST_COPY_DRAIN) |=> (out_valid && out_data.step_done))
		else $error("step completion lost");

	// a step result never carries a cell value
	a_step_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.step_done && out_data.cell_state))
		else $error("step result with cell value");

	// no transaction during the clearing pass
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lge_pkg::ST_CLEAR) |-> !accept && !gen_vld_s1 && !copy_vld_s1)
		else $error("activity during clearing pass");
`endif

endmodule

>>> bench/life_generation_engine_top_tb.sv
module life_generation_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 90;

	// Tracks the grid and registers, queues the result each transaction should give
	class grid_tracker;
		bit cells [GRID_ROWS][GRID_COLS];
		bit [lge_pkg::REG_W-1:0] rows_reg;
		bit [lge_pkg::REG_W-1:0] cols_reg;
		lge_pkg::out_item_t pending_cells [$];
		int unsigned failures;

		function new();
			foreach (cells[r, c])
				cells[r][c] = 1'b0;
			rows_reg = 7'd64;
			cols_reg = 7'd64;
			failures = 0;
		endfunction

		// Register value as the block uses it: clipped to 3..top
		function int span(bit [lge_pkg::REG_W-1:0] raw, int top);
			if (raw < lge_pkg::DIM_MIN)
				return int'(lge_pkg::DIM_MIN);
			if (raw > top)
				return top;
			return int'(raw);
		endfunction

		function void set_reg(logic idx, bit [lge_pkg::REG_W-1:0] val);
			if (idx == lge_pkg::CFG_ROWS)
				rows_reg = val;
			else
				cols_reg = val;
		endfunction

		// One Life generation over the in-use area, wrapping at its bounds
		function void advance_generation();
			bit fresh [GRID_ROWS][GRID_COLS];
			int nr;
			int nc;
			int live;
			nr = span(rows_reg, GRID_ROWS);
			nc = span(cols_reg, GRID_COLS);
			for (int r = 0; r < nr; r++) begin
				for (int c = 0; c < nc; c++) begin
					live = 0;
					for (int dr = -1; dr <= 1; dr++) begin
						for (int dc = -1; dc <= 1; dc++) begin
							if (dr != 0 || dc != 0)
								live += cells[(r + nr + dr) % nr][(c + nc + dc) % nc];
						end
					end
					fresh[r][c] = (live == lge_pkg::BORN_COUNT) ||
						(live == lge_pkg::KEEP_COUNT && cells[r][c]);
				end
			end
			for (int r = 0; r < nr; r++)
				for (int c = 0; c < nc; c++)
					cells[r][c] = fresh[r][c];
		endfunction

		// Accepted input transaction: update the grid and queue its result
		function void take_command(lge_pkg::in_item_t it);
			lge_pkg::out_item_t res;
			res = '0;
			case (it.command)
				lge_pkg::CMD_WRITE: begin
					cells[it.row][it.col] = it.cell_value;
					res.cell_state = it.cell_value;
				end
				lge_pkg::CMD_READ: begin
					res.cell_state = cells[it.row][it.col];
				end
				lge_pkg::CMD_STEP: begin
					advance_generation();
					res.step_done = 1'b1;
				end
				default: ;
			endcase
			pending_cells.push_back(res);
		endfunction

		// Accepted output transaction: compare with the oldest queued result
		function void match_result(lge_pkg::out_item_t got);
			lge_pkg::out_item_t want;
			if (pending_cells.size() == 0) begin
				$error("result with none pending: cell_state %b step_done %b",
					got.cell_state, got.step_done);
				failures++;
				return;
			end
			want = pending_cells.pop_front();
			if (got.cell_state !== want.cell_state) begin
				$error("cell_state: expected %b, actual %b", want.cell_state, got.cell_state);
				failures++;
			end
			if (got.step_done !== want.step_done) begin
				$error("step_done: expected %b, actual %b", want.step_done, got.step_done);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lge_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lge_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = lge_pkg::CFG_ROWS;
	logic [lge_pkg::REG_W-1:0] cfg_data = '0;

	grid_tracker tracker = new();
	int unsigned send_gap_pct = 0;
	int unsigned recv_gap_pct = 0;
	int unsigned phase_sent = 0;

	// raw register values per phase, clipping extremes included
	bit [lge_pkg::REG_W-1:0] phase_rows [PHASES] = '{7'd3, 7'd0, 7'd127, 7'd8, 7'd5, 7'd64,
		7'd17, 7'd12, 7'd127};
	bit [lge_pkg::REG_W-1:0] phase_cols [PHASES] = '{7'd3, 7'd127, 7'd2, 7'd8, 7'd11, 7'd64,
		7'd29, 7'd10, 7'd127};

	life_generation_engine_top #(
		.MAX_ROWS(GRID_ROWS),
		.MAX_COLS(GRID_COLS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: check accepted transactions, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.match_result(out_data);
		out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
	end

	// Present one transaction after an optional random gap; returns once accepted
	task automatic send_cmd(logic [1:0] cmd, int unsigned row, int unsigned col, bit val);
		lge_pkg::in_item_t it;
		it.command = cmd;
		it.row = 6'(row);
		it.col = 6'(col);
		it.cell_value = val;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_command(it);
		if (cmd != CMD_NONE)
			phase_sent++;
	endtask

	// Hold off input until every queued result has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_cells.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers on back-to-back cycles, enable held high across them
	task automatic set_dims(bit [lge_pkg::REG_W-1:0] rows_raw,
		bit [lge_pkg::REG_W-1:0] cols_raw);
		cfg_we <= 1'b1;
		cfg_index <= lge_pkg::CFG_ROWS;
		cfg_data <= rows_raw;
		@(posedge clk);
		tracker.set_reg(lge_pkg::CFG_ROWS, rows_raw);
		cfg_index <= lge_pkg::CFG_COLS;
		cfg_data <= cols_raw;
		@(posedge clk);
		tracker.set_reg(lge_pkg::CFG_COLS, cols_raw);
		cfg_we <= 1'b0;
	endtask

	// Full-grid generations are slow; allow them only now and then
	function automatic bit step_affordable(int nr, int nc);
		return (nr * nc <= 512) || ($urandom_range(0, 9) == 0);
	endfunction

	// Seed a small cluster, run one to three generations if affordable, then read around it
	task automatic play_cluster();
		int nr;
		int nc;
		int cr;
		int cc;
		nr = tracker.span(tracker.rows_reg, GRID_ROWS);
		nc = tracker.span(tracker.cols_reg, GRID_COLS);
		cr = $urandom_range(0, nr - 1);
		cc = $urandom_range(0, nc - 1);
		repeat ($urandom_range(3, 12))
			send_cmd(lge_pkg::CMD_WRITE, (cr + $urandom_range(0, 3)) % nr,
				(cc + $urandom_range(0, 3)) % nc, $urandom_range(0, 99) < 65);
		if (step_affordable(nr, nc)) begin
			repeat ($urandom_range(1, 3))
				send_cmd(lge_pkg::CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 1));
		end
		repeat ($urandom_range(3, 10))
			send_cmd(lge_pkg::CMD_READ, (cr + nr - 1 + $urandom_range(0, 5)) % nr,
				(cc + nc - 1 + $urandom_range(0, 5)) % nc, $urandom_range(0, 1));
	endtask

	// Any command anywhere on the physical grid, the unused code included
	task automatic play_noise();
		logic [1:0] cmd;
		int nr;
		int nc;
		nr = tracker.span(tracker.rows_reg, GRID_ROWS);
		nc = tracker.span(tracker.cols_reg, GRID_COLS);
		repeat ($urandom_range(1, 6)) begin
			cmd = 2'($urandom_range(0, 3));
			if (cmd == lge_pkg::CMD_STEP && !step_affordable(nr, nc))
				cmd = lge_pkg::CMD_READ;
			send_cmd(cmd, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 19;
		recv_gap_pct = 61;

		// cleared grid, corners, a block across the wrap, a blinker, overwrite
		send_cmd(lge_pkg::CMD_READ, 0, 0, 1'b1);
		send_cmd(lge_pkg::CMD_READ, 63, 63, 1'b0);
		send_cmd(lge_pkg::CMD_WRITE, 0, 0, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 63, 63, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 0, 63, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 63, 0, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 32, 10, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 32, 11, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 32, 12, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 5, 5, 1'b1);
		send_cmd(lge_pkg::CMD_WRITE, 5, 5, 1'b0);
		send_cmd(lge_pkg::CMD_WRITE, 21, 42, 1'b1);
		send_cmd(CMD_NONE, 42, 21, 1'b1);
		send_cmd(lge_pkg::CMD_STEP, 21, 42, 1'b0);
		send_cmd(lge_pkg::CMD_READ, 0, 0, 1'b0);
		send_cmd(lge_pkg::CMD_READ, 63, 63, 1'b1);
		send_cmd(lge_pkg::CMD_READ, 31, 11, 1'b0);
		send_cmd(lge_pkg::CMD_READ, 32, 10, 1'b0);
		send_cmd(lge_pkg::CMD_READ, 33, 11, 1'b1);
		send_cmd(lge_pkg::CMD_READ, 21, 42, 1'b0);
		send_cmd(lge_pkg::CMD_READ, 5, 5, 1'b1);
		settle();

		// random phases, one register setting each
		for (int p = 0; p < PHASES; p++) begin
			if (p == 3) begin
				send_gap_pct = 61;
				recv_gap_pct = 19;
			end else if (p == 6) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			set_dims(phase_rows[p], phase_cols[p]);
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 75)
					play_cluster();
				else
					play_noise();
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_cells.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// run limit, well above the slowest correct run
	initial begin
		#(4_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
rtl/lge_pkg.sv
rtl/lge_ram.sv
rtl/life_generation_engine_top.sv
bench/life_generation_engine_top_tb.sv
